/* sv/assert_macros.svh */
// Assertion helpers shared by the fusion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define CHK_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/mwgf_pkg.sv */
package mwgf_pkg;

	localparam int EV_KINDS  = 7;
	localparam int SCORE_W   = 16;
	localparam int WEIGHT_W  = 10;
	localparam int CFG_IDX_W = 3;
	localparam int SCORE_LO  = 66;
	localparam int SCORE_HI  = 65470;
	// negative log2 in Q16, at most 10.0 for clamped scores
	localparam int D_W       = 20;
	localparam int PROD_W    = WEIGHT_W + D_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int WSUM_W    = WEIGHT_W + 3;
	localparam int Q_W       = D_W;
	localparam int DIV_STEP  = 2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [EV_KINDS] =
		'{10'd256, 10'd77, 10'd128, 10'd205, 10'd179, 10'd230, 10'd154};

	typedef enum logic [1:0] {
		OUT_FUSED    = 2'd0,
		OUT_FALLBACK = 2'd1,
		OUT_ZERO     = 2'd2
	} outcome_t;

	typedef struct packed {
		outcome_t             outcome;
		logic [SCORE_W-1:0]   fallback;
	} side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = '0;
		b = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// log2(1 + idx/2^tbits) in Q16, from a 30-bit squaring log
	function automatic logic [63:0] log_entry(input int idx, input int tbits);
		logic [63:0] x;
		logic [63:0] v;
		x = (64'd1 << 30) + (64'(idx) << (30 - tbits));
		v = '0;
		for (int k = 1; k <= 30; k++) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				v = v | (64'd1 << (30 - k));
				x = x >> 1;
			end
		end
		return (v + (64'd1 << 13)) >> 14;
	endfunction

	// 2^(idx/2^tbits) in Q30, chained square roots of two
	function automatic logic [63:0] exp_entry(input int idx, input int tbits);
		logic [63:0] root;
		logic [63:0] e;
		root = isqrt64(64'd2 << 60);
		e = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			if (k <= tbits) begin
				if (((idx >> (tbits - k)) & 1) != 0)
					e = (e * root + (64'd1 << 29)) >> 30;
				root = isqrt64(root << 30);
			end
		end
		return e;
	endfunction

endpackage

/* sv/masked_weighted_geomean_fusion.sv */
// Masked weighted geometric-mean confidence fusion.
// Item channel: item_valid / item_stall carry one candidate (flag, 7-bit mask,
// fallback and seven Q0.16 scores); a transaction completes when valid is high
// and stall is low. Result channel: result_valid / result_stall carry the
// Q0.16 fused_confidence and a 2-bit outcome (fused, fallback, forced zero).
// Config channel: cfg_valid / cfg_ready (always ready) writes one Q8 weight
// per transaction at cfg_index; indexes beyond the seven weights are dropped.
// Write weights only while no transaction is in flight.
// Throughput: one transaction per cycle while the result channel is not stalled.
// The pipe has 19 register stages: 6 log/mean stages, 10 divider stages of two
// quotient bits each, 3 exp stages. Each stage moves when the one after it is
// empty or moving, so bubbles are squeezed out and a stalled receiver backs the
// pipe up one stage at a time.
// Reset clears all valid bits and loads the default weights; the log2/exp2
// tables are constants and need no fill.
`include "assert_macros.svh"

module masked_weighted_geomean_fusion #(
	parameter int TABLE_ADDR_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mwgf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mwgf_pkg::WEIGHT_W-1:0]       cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                has_candidate,
	input  logic [mwgf_pkg::EV_KINDS-1:0]       kind_mask,
	input  logic [mwgf_pkg::SCORE_W-1:0]        fallback_confidence,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_magic,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_extension,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_size,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_header,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_layout,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_checksum,
	input  logic [mwgf_pkg::SCORE_W-1:0]        score_content,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [mwgf_pkg::SCORE_W-1:0]        fused_confidence,
	output logic [1:0]                          outcome
);

	localparam int EV      = mwgf_pkg::EV_KINDS;
	localparam int SW      = mwgf_pkg::SCORE_W;
	localparam int T       = TABLE_ADDR_BITS;
	localparam int TBL     = 1 << T;
	localparam int IW      = SW + T + 1;
	localparam int FRAC_SH = 16 - T;
	localparam int ROUND_J = 1 << (FRAC_SH - 1);

	// ---------------- constant tables ----------------
	logic [16:0] log_rom [TBL];
	logic [30:0] exp_rom [TBL];

	for (genvar g = 0; g < TBL; g++) begin : g_rom
		assign log_rom[g] = 17'(mwgf_pkg::log_entry(g, T));
		assign exp_rom[g] = 31'(mwgf_pkg::exp_entry(g, T));
	end

	// ---------------- weight registers ----------------
	logic [mwgf_pkg::WEIGHT_W-1:0] weight_q [EV];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EV; i++)
				weight_q[i] <= mwgf_pkg::WEIGHT_RESET[i];
		end else if (cfg_valid && cfg_ready &&
			(cfg_index < mwgf_pkg::CFG_IDX_W'(EV))) begin
			weight_q[cfg_index] <= cfg_data;
		end
	end

	// ---------------- stage enables ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic div_stall, div_valid;

	assign en_s9 = !v_s9 || !result_stall;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || !div_stall;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign item_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= div_valid;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// ---------------- s1: clamp, leading one, case select ----------------
	logic [SW-1:0]   score_in [EV];
	logic [SW-1:0]   clamp_c  [EV];
	logic [3:0]      lead_c   [EV];
	mwgf_pkg::side_t side_c;

	assign score_in[0] = score_magic;
	assign score_in[1] = score_extension;
	assign score_in[2] = score_size;
	assign score_in[3] = score_header;
	assign score_in[4] = score_layout;
	assign score_in[5] = score_checksum;
	assign score_in[6] = score_content;

	always_comb begin
		for (int i = 0; i < EV; i++) begin
			clamp_c[i] = score_in[i];
			if (clamp_c[i] < SW'(mwgf_pkg::SCORE_LO)) clamp_c[i] = SW'(mwgf_pkg::SCORE_LO);
			if (clamp_c[i] > SW'(mwgf_pkg::SCORE_HI)) clamp_c[i] = SW'(mwgf_pkg::SCORE_HI);
			lead_c[i] = '0;
			for (int t = 0; t < SW; t++)
				if (clamp_c[i][t]) lead_c[i] = 4'(t);
		end
		side_c.fallback = fallback_confidence;
		priority if (!has_candidate) side_c.outcome = mwgf_pkg::OUT_ZERO;
		else if (kind_mask == '0) side_c.outcome = mwgf_pkg::OUT_FALLBACK;
		else side_c.outcome = mwgf_pkg::OUT_FUSED;
	end

	mwgf_pkg::side_t side_s1;
	logic [EV-1:0]   act_s1;
	logic [SW-1:0]   sc_s1 [EV];
	logic [3:0]      p_s1  [EV];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= side_c;
			act_s1  <= kind_mask;
			for (int i = 0; i < EV; i++) begin
				sc_s1[i] <= clamp_c[i];
				p_s1[i]  <= lead_c[i];
			end
		end
	end

	// ---------------- s2: round mantissa to table index ----------------
	logic [4:0]   p_c2   [EV];
	logic [T-1:0] idx_c2 [EV];

	always_comb begin
		logic [SW-1:0] frac;
		logic [IW-1:0] idxf;
		frac = '0;
		idxf = '0;
		for (int i = 0; i < EV; i++) begin
			frac = sc_s1[i] & ~(SW'(1) << p_s1[i]);
			// leading one is at bit 6 or above after the clamp
			idxf = ((IW'(frac) << T) + (IW'(1) << (p_s1[i] - 4'd1))) >> p_s1[i];
			if (idxf[T]) begin
				p_c2[i]   = {1'b0, p_s1[i]} + 5'd1;
				idx_c2[i] = '0;
			end else begin
				p_c2[i]   = {1'b0, p_s1[i]};
				idx_c2[i] = idxf[T-1:0];
			end
		end
	end

	mwgf_pkg::side_t side_s2;
	logic [EV-1:0]   act_s2;
	logic [4:0]      p_s2   [EV];
	logic [T-1:0]    idx_s2 [EV];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			side_s2 <= side_s1;
			act_s2  <= act_s1;
			p_s2    <= p_c2;
			idx_s2  <= idx_c2;
		end
	end

	// ---------------- s3: negative log2 per lane ----------------
	logic [mwgf_pkg::D_W-1:0] d_c3 [EV];

	always_comb begin
		logic [20:0] full;
		full = '0;
		for (int i = 0; i < EV; i++) begin
			full = {(5'd16 - p_s2[i]), 16'd0} - {4'd0, log_rom[idx_s2[i]]};
			d_c3[i] = act_s2[i] ? full[mwgf_pkg::D_W-1:0] : '0;
		end
	end

	mwgf_pkg::side_t          side_s3;
	logic [EV-1:0]            act_s3;
	logic [mwgf_pkg::D_W-1:0] d_s3 [EV];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			side_s3 <= side_s2;
			act_s3  <= act_s2;
			d_s3    <= d_c3;
		end
	end

	// ---------------- s4: weight products ----------------
	logic [mwgf_pkg::PROD_W-1:0] prod_c4 [EV];
	logic [mwgf_pkg::WSUM_W-1:0] wsum_c4;

	always_comb begin
		wsum_c4 = '0;
		for (int i = 0; i < EV; i++) begin
			prod_c4[i] = mwgf_pkg::PROD_W'(weight_q[i]) * mwgf_pkg::PROD_W'(d_s3[i]);
			if (act_s3[i]) wsum_c4 = wsum_c4 + mwgf_pkg::WSUM_W'(weight_q[i]);
		end
	end

	mwgf_pkg::side_t             side_s4;
	logic [mwgf_pkg::PROD_W-1:0] prod_s4 [EV];
	logic [mwgf_pkg::WSUM_W-1:0] wsum_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			side_s4 <= side_s3;
			prod_s4 <= prod_c4;
			wsum_s4 <= wsum_c4;
		end
	end

	// ---------------- s5: partial sums ----------------
	logic [mwgf_pkg::ACC_W-1:0] acc_a_c5, acc_b_c5;

	always_comb begin
		acc_a_c5 = '0;
		acc_b_c5 = '0;
		for (int i = 0; i < EV; i++) begin
			if (i < 4) acc_a_c5 = acc_a_c5 + mwgf_pkg::ACC_W'(prod_s4[i]);
			else acc_b_c5 = acc_b_c5 + mwgf_pkg::ACC_W'(prod_s4[i]);
		end
	end

	mwgf_pkg::side_t             side_s5;
	logic [mwgf_pkg::ACC_W-1:0]  acc_a_s5, acc_b_s5;
	logic [mwgf_pkg::WSUM_W-1:0] wsum_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			side_s5  <= side_s4;
			acc_a_s5 <= acc_a_c5;
			acc_b_s5 <= acc_b_c5;
			wsum_s5  <= wsum_s4;
		end
	end

	// ---------------- s6: rounded dividend, zero-weight check ----------------
	mwgf_pkg::side_t side_c6;

	always_comb begin
		side_c6 = side_s5;
		if (side_s5.outcome == mwgf_pkg::OUT_FUSED && wsum_s5 == '0)
			side_c6.outcome = mwgf_pkg::OUT_ZERO;
	end

	mwgf_pkg::side_t             side_s6;
	logic [mwgf_pkg::ACC_W-1:0]  num_s6;
	logic [mwgf_pkg::WSUM_W-1:0] wsum_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			side_s6 <= side_c6;
			num_s6  <= acc_a_s5 + acc_b_s5 + mwgf_pkg::ACC_W'(wsum_s5 >> 1);
			wsum_s6 <= wsum_s5;
		end
	end

	// ---------------- divider: mean of the logs ----------------
	logic [mwgf_pkg::Q_W-1:0] div_quo;
	mwgf_pkg::side_t          div_side;

	mwgf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_stall  (div_stall),
		.num       (num_s6),
		.den       (wsum_s6),
		.in_side   (side_s6),
		.out_valid (div_valid),
		.out_stall (!en_s7),
		.quo       (div_quo),
		.out_side  (div_side)
	);

	// ---------------- s7: split mean, round fraction ----------------
	logic [4:0]   q_c7;
	logic [T-1:0] j_c7;

	always_comb begin
		logic [16:0] jf;
		jf = (17'(div_quo[15:0]) + 17'(ROUND_J)) >> FRAC_SH;
		if (jf[T]) begin
			q_c7 = {1'b0, div_quo[19:16]} + 5'd1;
			j_c7 = '0;
		end else begin
			q_c7 = {1'b0, div_quo[19:16]};
			j_c7 = jf[T-1:0];
		end
	end

	mwgf_pkg::side_t side_s7;
	logic [4:0]      q_s7;
	logic [T-1:0]    j_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			side_s7 <= div_side;
			q_s7    <= q_c7;
			j_s7    <= j_c7;
		end
	end

	// ---------------- s8: exp2 table, shift amount ----------------
	logic [T-1:0] jn_c8;
	logic         jz_c8;

	assign jz_c8 = (j_s7 == '0);
	assign jn_c8 = '0 - j_s7;

	mwgf_pkg::side_t side_s8;
	logic [30:0]     r_s8;
	logic [5:0]      sh_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			side_s8 <= side_s7;
			r_s8    <= jz_c8 ? (31'd1 << 30) : exp_rom[jn_c8];
			sh_s8   <= 6'd14 + {1'b0, q_s7} + {5'd0, !jz_c8};
		end
	end

	// ---------------- s9: round to Q0.16, saturate, select ----------------
	logic [SW-1:0] res_c9;

	always_comb begin
		logic [30:0] rnd;
		logic [31:0] full;
		rnd  = r_s8 >> (sh_s8 - 6'd1);
		full = (32'(rnd) + 32'd1) >> 1;
		if (full > 32'(2 ** SW - 1)) full = 32'(2 ** SW - 1);
		unique case (side_s8.outcome)
			mwgf_pkg::OUT_FUSED:    res_c9 = full[SW-1:0];
			mwgf_pkg::OUT_FALLBACK: res_c9 = side_s8.fallback;
			default:                res_c9 = '0;
		endcase
	end

	logic [SW-1:0]     res_s9;
	mwgf_pkg::outcome_t oc_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			res_s9 <= res_c9;
			oc_s9  <= side_s8.outcome;
		end
	end

	assign result_valid     = v_s9;
	assign fused_confidence = res_s9;
	assign outcome          = oc_s9;

	`CHK_IMP(a_zero_result, clk, arst_n,
		result_valid && (outcome == mwgf_pkg::OUT_ZERO), fused_confidence == '0)
	`CHK_IMP(a_fused_has_weight, clk, arst_n,
		v_s6 && (side_s6.outcome == mwgf_pkg::OUT_FUSED), wsum_s6 != '0)
	`CHK_NXT(a_accept_lands, clk, arst_n, item_valid && !item_stall, v_s1)

endmodule

/* sv/mwgf_div.sv */
`include "assert_macros.svh"

// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module mwgf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mwgf_pkg::ACC_W-1:0]    num,
	input  logic [mwgf_pkg::WSUM_W-1:0]   den,
	input  mwgf_pkg::side_t               in_side,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mwgf_pkg::Q_W-1:0]      quo,
	output mwgf_pkg::side_t               out_side
);

	localparam int NS = (mwgf_pkg::Q_W + mwgf_pkg::DIV_STEP - 1) / mwgf_pkg::DIV_STEP;
	localparam int RW = mwgf_pkg::WSUM_W;
	localparam int QW = mwgf_pkg::Q_W;

	logic                v_s   [NS];
	logic [RW-1:0]       rem_s [NS];
	logic [QW-1:0]       nq_s  [NS];
	logic [RW-1:0]       den_s [NS];
	mwgf_pkg::side_t     side_s[NS];
	logic [NS-1:0]       en;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic            v_src;
		logic [RW-1:0]   r_src;
		logic [QW-1:0]   n_src;
		logic [RW-1:0]   d_src;
		mwgf_pkg::side_t side_src;
		logic [RW-1:0]   r_nxt;
		logic [QW-1:0]   n_nxt;

		if (g == 0) begin : g_first
			// quotient fits QW bits, so the top part is already below den
			assign v_src    = in_valid;
			assign r_src    = RW'(num >> QW);
			assign n_src    = num[QW-1:0];
			assign d_src    = den;
			assign side_src = in_side;
		end else begin : g_next
			assign v_src    = v_s[g-1];
			assign r_src    = rem_s[g-1];
			assign n_src    = nq_s[g-1];
			assign d_src    = den_s[g-1];
			assign side_src = side_s[g-1];
		end

		if (g == NS - 1) begin : g_last_en
			assign en[g] = !v_s[g] || !out_stall;
		end else begin : g_mid_en
			assign en[g] = !v_s[g] || en[g+1];
		end

		always_comb begin
			logic [RW:0] t;
			r_nxt = r_src;
			n_nxt = n_src;
			t = '0;
			for (int k = 0; k < mwgf_pkg::DIV_STEP; k++) begin
				if (g * mwgf_pkg::DIV_STEP + k < QW) begin
					t = {r_nxt, n_nxt[QW-1]};
					n_nxt = {n_nxt[QW-2:0], 1'b0};
					if (t >= {1'b0, d_src}) begin
						t = t - {1'b0, d_src};
						n_nxt[0] = 1'b1;
					end
					r_nxt = t[RW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en[g]) begin
				v_s[g] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g]  <= r_nxt;
				nq_s[g]   <= n_nxt;
				den_s[g]  <= d_src;
				side_s[g] <= side_src;
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_s[NS-1];
	assign quo       = nq_s[NS-1];
	assign out_side  = side_s[NS-1];

	`CHK_IMP(a_rem_below_den, clk, arst_n,
		v_s[NS-1] && (den_s[NS-1] != 0), rem_s[NS-1] < den_s[NS-1])
	`CHK_NXT(a_take_fills, clk, arst_n, in_valid && en[0], v_s[0])

endmodule
